>>> rtl/core/assert_macros.svh
// Assertion macros for the alpha finalize RTL.
// Uses the clk and rst_n names of the including module; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset.
`define AFB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Next-cycle implication, disabled during reset.
`define AFB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define AFB_ASSERT_IMP(lbl, ante, cons)
`define AFB_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> rtl/core/afb_pkg.sv
// Package for the alpha finalize block: widths, codes, structs, clamp function.
// No dependencies; used by afb_pixel_unit and the top level.
`default_nettype none
package afb_pkg;

  localparam int MAX_DIM    = 4096;
  localparam int DIM_W      = 13;
  localparam int POS_W      = 12;
  localparam int CNT_W      = 25;
  localparam int CH_W       = 8;
  localparam int MODE_W     = 2;
  localparam int THR_W      = 8;
  localparam int BORDER_W   = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;

  localparam logic [MODE_W-1:0] MODE_PRESERVE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BINARY   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OPAQUE   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_THRESH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_VISIBLE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_BORDER   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd5;

  localparam logic [MODE_W-1:0]   RST_ALPHA_MODE   = MODE_PRESERVE;
  localparam logic [THR_W-1:0]    RST_ALPHA_THRESH = 8'd128;
  localparam logic [CNT_W-1:0]    RST_MIN_VISIBLE  = 25'd1;
  localparam logic [BORDER_W-1:0] RST_MIN_BORDER   = 11'd0;
  localparam logic [DIM_W-1:0]    RST_FRAME_DIM    = 13'd64;

  localparam logic [CH_W-1:0] ALPHA_FULL = 8'd255;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FEW    = 2'd1,
    ST_BORDER = 2'd2
  } status_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
  } pix_t;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [THR_W-1:0]    threshold;
    logic [CNT_W-1:0]    min_visible;
    logic [BORDER_W-1:0] min_border;
    logic [DIM_W-1:0]    width;
    logic [DIM_W-1:0]    height;
  } cfg_t;

  typedef struct packed {
    pix_t             pix;
    logic             frame_done;
    status_t          status;
    logic [CNT_W-1:0] visible_total;
    logic [DIM_W-1:0] box_left;
    logic [DIM_W-1:0] box_top;
    logic [DIM_W-1:0] box_right;
    logic [DIM_W-1:0] box_bottom;
  } result_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      res = DIM_W'(MAX_DIM);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/alpha_finalize_with_bounds_top.sv
// Top level of the alpha finalize block: config registers, input and output stages.
// Depends on afb_pkg, afb_pixel_unit and assert_macros.svh.
//
// Usage:
//   Input channel in_*: one RGBA pixel per transaction, raster order, for a
//   frame of frame_width x frame_height pixels (each clamped to 1..4096).
//   Output channel out_*: one finalized pixel per input transaction. On the
//   frame's last pixel frame_done is 1 and the status, visible count and
//   bounding box are valid; on other pixels those report fields are zero.
//   Config port cfg_*: write enable, register index, data; no wait state.
//   Write only while idle. A frame_width or frame_height write restarts the
//   frame; other writes apply from the next pixel.
// Datapath: the input register feeds the result register, which drives
//   out_valid. Throughput: one pixel per clock while out_ready stays high.
// Stall: when out_ready is low the result register holds; the input register
//   takes a pixel only while empty, and in_ready drops once it holds one.
// Reset (rst_n, synchronous, active low): registers go to their defaults
//   (preserve, threshold 128, min_visible 1, border 0, 64 x 64), the frame
//   position and accumulators clear, and both channels go empty.
`default_nettype none
`include "assert_macros.svh"
module alpha_finalize_with_bounds_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [afb_pkg::CH_W-1:0]      in_red_in,
  input  wire logic [afb_pkg::CH_W-1:0]      in_green_in,
  input  wire logic [afb_pkg::CH_W-1:0]      in_blue_in,
  input  wire logic [afb_pkg::CH_W-1:0]      in_alpha_in,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [afb_pkg::CH_W-1:0]           out_red_out,
  output logic [afb_pkg::CH_W-1:0]           out_green_out,
  output logic [afb_pkg::CH_W-1:0]           out_blue_out,
  output logic [afb_pkg::CH_W-1:0]           out_alpha_out,
  output logic                               out_frame_done,
  output logic [1:0]                         out_frame_status,
  output logic [afb_pkg::CNT_W-1:0]          out_visible_total,
  output logic [afb_pkg::DIM_W-1:0]          out_box_left,
  output logic [afb_pkg::DIM_W-1:0]          out_box_top,
  output logic [afb_pkg::DIM_W-1:0]          out_box_right,
  output logic [afb_pkg::DIM_W-1:0]          out_box_bottom,
  input  wire logic                          cfg_we,
  input  wire logic [afb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [afb_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers; dimensions are kept raw and clamped on use.
  logic [afb_pkg::MODE_W-1:0]   mode_r, mode_nxt;
  logic [afb_pkg::THR_W-1:0]    thr_r, thr_nxt;
  logic [afb_pkg::CNT_W-1:0]    minvis_r, minvis_nxt;
  logic [afb_pkg::BORDER_W-1:0] border_r, border_nxt;
  logic [afb_pkg::DIM_W-1:0]    width_r, width_nxt;
  logic [afb_pkg::DIM_W-1:0]    height_r, height_nxt;
  logic                         geom_clr;
  afb_pkg::cfg_t                cfg;

  // Input stage and result stage.
  logic                s1_valid_r, s1_valid_nxt;
  afb_pkg::pix_t       s1_pix_r;
  logic                s1_adv, step, in_take;
  logic                out_valid_r, out_valid_nxt;
  afb_pkg::result_t    out_r;
  afb_pkg::result_t    res;

  always_comb begin
    mode_nxt   = mode_r;
    thr_nxt    = thr_r;
    minvis_nxt = minvis_r;
    border_nxt = border_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    geom_clr   = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        afb_pkg::REG_ALPHA_MODE: begin
          mode_nxt = cfg_wdata[afb_pkg::MODE_W-1:0];
        end
        afb_pkg::REG_ALPHA_THRESH: begin
          thr_nxt = cfg_wdata[afb_pkg::THR_W-1:0];
        end
        afb_pkg::REG_MIN_VISIBLE: begin
          minvis_nxt = cfg_wdata[afb_pkg::CNT_W-1:0];
        end
        afb_pkg::REG_MIN_BORDER: begin
          border_nxt = cfg_wdata[afb_pkg::BORDER_W-1:0];
        end
        afb_pkg::REG_FRAME_WIDTH: begin
          width_nxt = cfg_wdata[afb_pkg::DIM_W-1:0];
          geom_clr  = 1'b1;
        end
        afb_pkg::REG_FRAME_HEIGHT: begin
          height_nxt = cfg_wdata[afb_pkg::DIM_W-1:0];
          geom_clr   = 1'b1;
        end
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= afb_pkg::RST_ALPHA_MODE;
      thr_r    <= afb_pkg::RST_ALPHA_THRESH;
      minvis_r <= afb_pkg::RST_MIN_VISIBLE;
      border_r <= afb_pkg::RST_MIN_BORDER;
      width_r  <= afb_pkg::RST_FRAME_DIM;
      height_r <= afb_pkg::RST_FRAME_DIM;
    end else begin
      mode_r   <= mode_nxt;
      thr_r    <= thr_nxt;
      minvis_r <= minvis_nxt;
      border_r <= border_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  always_comb begin
    cfg.mode        = mode_r;
    cfg.threshold   = thr_r;
    cfg.min_visible = minvis_r;
    cfg.min_border  = border_r;
    cfg.width       = afb_pkg::clamp_dim(width_r);
    cfg.height      = afb_pkg::clamp_dim(height_r);
  end

  // Advance the input stage whenever the result register is free or drains.
  assign s1_adv   = !out_valid_r || out_ready;
  assign step     = s1_valid_r && s1_adv;
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_take  = in_valid && in_ready;

  assign s1_valid_nxt  = in_take ? 1'b1 : (step ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = step ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: load on transaction, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_pix_r.red   <= in_red_in;
      s1_pix_r.green <= in_green_in;
      s1_pix_r.blue  <= in_blue_in;
      s1_pix_r.alpha <= in_alpha_in;
    end
    if (step) begin
      out_r <= res;
    end
  end

  afb_pixel_unit u_pixel (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .step       (step),
    .pix        (s1_pix_r),
    .clr        (geom_clr),
    .clr_width  (afb_pkg::clamp_dim(width_nxt)),
    .clr_height (afb_pkg::clamp_dim(height_nxt)),
    .res        (res)
  );

  assign out_valid         = out_valid_r;
  assign out_red_out       = out_r.pix.red;
  assign out_green_out     = out_r.pix.green;
  assign out_blue_out      = out_r.pix.blue;
  assign out_alpha_out     = out_r.pix.alpha;
  assign out_frame_done    = out_r.frame_done;
  assign out_frame_status  = out_r.status;
  assign out_visible_total = out_r.visible_total;
  assign out_box_left      = out_r.box_left;
  assign out_box_top       = out_r.box_top;
  assign out_box_right     = out_r.box_right;
  assign out_box_bottom    = out_r.box_bottom;

  // A pending pixel waits in the input stage until the result side frees up.
  `AFB_ASSERT_NXT(a_s1_hold, s1_valid_r && !s1_adv, s1_valid_r)
  // An empty result register never back-pressures the input.
  `AFB_ASSERT_IMP(a_ready_free, !out_valid_r, in_ready)
  // Report fields are zero away from the frame's last pixel.
  `AFB_ASSERT_IMP(a_report_zero, out_valid_r && !out_r.frame_done,
                  out_r.visible_total == '0 && out_r.box_right == '0)
  // A frame with visible pixels has a non-empty box.
  `AFB_ASSERT_IMP(a_box_order,
                  out_valid_r && out_r.frame_done && out_r.visible_total != '0,
                  out_r.box_left < out_r.box_right && out_r.box_top < out_r.box_bottom)

endmodule
`default_nettype wire

>>> rtl/core/afb_pixel_unit.sv
// Per-pixel alpha finalize plus frame position, count and bounding box state.
// Depends on afb_pkg.
`default_nettype none
module afb_pixel_unit (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire afb_pkg::cfg_t           cfg,
  input  wire logic                    step,
  input  wire afb_pkg::pix_t           pix,
  input  wire logic                    clr,
  input  wire logic [afb_pkg::DIM_W-1:0] clr_width,
  input  wire logic [afb_pkg::DIM_W-1:0] clr_height,
  output afb_pkg::result_t             res
);

  logic [afb_pkg::POS_W-1:0] col_r, col_nxt;
  logic [afb_pkg::POS_W-1:0] row_r, row_nxt;
  logic [afb_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [afb_pkg::DIM_W-1:0] left_r, left_nxt;
  logic [afb_pkg::DIM_W-1:0] top_r, top_nxt;
  logic [afb_pkg::DIM_W-1:0] right_r, right_nxt;
  logic [afb_pkg::DIM_W-1:0] bottom_r, bottom_nxt;

  logic [afb_pkg::CH_W-1:0]  a_fin;
  logic                      vis;
  logic [afb_pkg::DIM_W-1:0] col_ext, row_ext, col_inc, row_inc;
  logic [afb_pkg::CNT_W-1:0] cnt_upd;
  logic [afb_pkg::DIM_W-1:0] left_upd, top_upd, right_upd, bottom_upd;
  logic                      row_end, last, border_ok;
  logic [afb_pkg::DIM_W:0]   right_need, bottom_need;
  logic [afb_pkg::DIM_W-1:0] border_ext;
  afb_pkg::status_t          status;

  always_comb begin
    case (cfg.mode)
      afb_pkg::MODE_OPAQUE: begin
        a_fin = afb_pkg::ALPHA_FULL;
      end
      afb_pkg::MODE_BINARY: begin
        if (pix.alpha < cfg.threshold || pix.alpha == '0) begin
          a_fin = '0;
        end else begin
          a_fin = afb_pkg::ALPHA_FULL;
        end
      end
      default: begin
        a_fin = pix.alpha;
      end
    endcase
  end

  assign vis     = (a_fin != '0);
  assign col_ext = {1'b0, col_r};
  assign row_ext = {1'b0, row_r};
  assign col_inc = col_ext + afb_pkg::DIM_W'(1);
  assign row_inc = row_ext + afb_pkg::DIM_W'(1);

  // Accumulators including the current pixel; the report shows these.
  assign cnt_upd    = vis ? cnt_r + afb_pkg::CNT_W'(1) : cnt_r;
  assign left_upd   = (vis && col_ext < left_r) ? col_ext : left_r;
  assign top_upd    = (vis && row_ext < top_r) ? row_ext : top_r;
  assign right_upd  = (vis && col_inc > right_r) ? col_inc : right_r;
  assign bottom_upd = (vis && row_inc > bottom_r) ? row_inc : bottom_r;

  assign row_end = (col_inc >= cfg.width);
  assign last    = row_end && (row_inc >= cfg.height);

  assign border_ext  = {2'b00, cfg.min_border};
  assign right_need  = {1'b0, right_upd} + {1'b0, border_ext};
  assign bottom_need = {1'b0, bottom_upd} + {1'b0, border_ext};
  assign border_ok   = (left_upd >= border_ext) && (top_upd >= border_ext) &&
                       (right_need <= {1'b0, cfg.width}) &&
                       (bottom_need <= {1'b0, cfg.height});

  always_comb begin
    status = afb_pkg::ST_OK;
    if (cnt_upd < cfg.min_visible) begin
      status = afb_pkg::ST_FEW;
    end else if (cfg.mode != afb_pkg::MODE_OPAQUE && !border_ok) begin
      status = afb_pkg::ST_BORDER;
    end
  end

  always_comb begin
    res.pix.red   = vis ? pix.red   : '0;
    res.pix.green = vis ? pix.green : '0;
    res.pix.blue  = vis ? pix.blue  : '0;
    res.pix.alpha = a_fin;
    res.frame_done    = last;
    res.status        = last ? status : afb_pkg::ST_OK;
    res.visible_total = last ? cnt_upd : '0;
    res.box_left      = last ? left_upd : '0;
    res.box_top       = last ? top_upd : '0;
    res.box_right     = last ? right_upd : '0;
    res.box_bottom    = last ? bottom_upd : '0;
  end

  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    cnt_nxt    = cnt_r;
    left_nxt   = left_r;
    top_nxt    = top_r;
    right_nxt  = right_r;
    bottom_nxt = bottom_r;
    if (clr) begin
      col_nxt    = '0;
      row_nxt    = '0;
      cnt_nxt    = '0;
      left_nxt   = clr_width;
      top_nxt    = clr_height;
      right_nxt  = '0;
      bottom_nxt = '0;
    end else if (step) begin
      if (last) begin
        col_nxt    = '0;
        row_nxt    = '0;
        cnt_nxt    = '0;
        left_nxt   = cfg.width;
        top_nxt    = cfg.height;
        right_nxt  = '0;
        bottom_nxt = '0;
      end else begin
        cnt_nxt    = cnt_upd;
        left_nxt   = left_upd;
        top_nxt    = top_upd;
        right_nxt  = right_upd;
        bottom_nxt = bottom_upd;
        if (row_end) begin
          col_nxt = '0;
          row_nxt = row_inc[afb_pkg::POS_W-1:0];
        end else begin
          col_nxt = col_inc[afb_pkg::POS_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      cnt_r    <= '0;
      left_r   <= afb_pkg::RST_FRAME_DIM;
      top_r    <= afb_pkg::RST_FRAME_DIM;
      right_r  <= '0;
      bottom_r <= '0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      cnt_r    <= cnt_nxt;
      left_r   <= left_nxt;
      top_r    <= top_nxt;
      right_r  <= right_nxt;
      bottom_r <= bottom_nxt;
    end
  end

endmodule
`default_nettype wire
